>>> sv/xmoe_pkg.sv
// Shared types and constants for the x86 memory operand encoder.
// No dependencies.
`default_nettype none
package xmoe_pkg;

  localparam int MaxBytes = 10;
  localparam int CntW     = $clog2(MaxBytes + 1);
  localparam int PosW     = $clog2(MaxBytes);

  typedef enum logic {
    FORM_GP  = 1'b0,
    FORM_SSE = 1'b1
  } form_t;

  typedef enum logic [1:0] {
    MOD_NODISP = 2'd0,
    MOD_DISP8  = 2'd1,
    MOD_DISP32 = 2'd2,
    MOD_REG    = 2'd3
  } mod_t;

  localparam logic [7:0] REX_BASE   = 8'h40;
  localparam logic [7:0] ESC_0F     = 8'h0f;
  localparam logic [7:0] SIB_NOIDX  = 8'h24;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIPBP   = 3'd5;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } enc_t;

endpackage
`default_nettype wire

>>> sv/x86_memory_operand_encoder_top.sv
// With the serializer idle, an accepted instruction (3 to 10 bytes) is registered in the
// input register, then loaded into the serializer register, which offers its first byte.
// Throughput: one byte per cycle unless stalled by out_ready, set by the single byte-wide
// output serializer. Input register refills while bytes drain.
// Reset (rst, synchronous) empties the input register and the serializer.
// Depends on xmoe_pkg, xmoe_encode, xmoe_serial.
`default_nettype none
module x86_memory_operand_encoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic [7:0]         opcode_byte,
  input  wire logic [7:0]         prefix_byte,
  input  wire logic signed [31:0] displacement,
  input  wire logic [3:0]         base_reg,
  input  wire logic [3:0]         data_reg,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              code_byte,
  output logic                    last
);

  logic               hold_valid;
  logic               h_cmd;
  logic [7:0]         h_opcode;
  logic [7:0]         h_prefix;
  logic signed [31:0] h_disp;
  logic [3:0]         h_base;
  logic [3:0]         h_data;
  logic               take;
  xmoe_pkg::enc_t     enc;

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_cmd    <= cmd;
      h_opcode <= opcode_byte;
      h_prefix <= prefix_byte;
      h_disp   <= displacement;
      h_base   <= base_reg;
      h_data   <= data_reg;
    end
  end

  xmoe_encode u_encode (
    .cmd          (h_cmd),
    .opcode_byte  (h_opcode),
    .prefix_byte  (h_prefix),
    .displacement (h_disp),
    .base_reg     (h_base),
    .data_reg     (h_data),
    .enc          (enc)
  );

  xmoe_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (hold_valid),
    .load      (take),
    .enc       (enc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .last      (last)
  );

  a_take_needs_hold: assert property (@(posedge clk) disable iff (rst)
    take |-> hold_valid)
    else $error("serializer loaded from empty input register");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !take) |=> hold_valid && $stable(h_disp) && $stable(h_opcode))
    else $error("pending instruction lost");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("loaded instruction not offered");

endmodule
`default_nettype wire

>>> sv/xmoe_encode.sv
// Combinational encoder: builds the full byte string and byte count of one instruction.
// Depends on xmoe_pkg.
`default_nettype none
module xmoe_encode (
  input  wire logic               cmd,
  input  wire logic [7:0]         opcode_byte,
  input  wire logic [7:0]         prefix_byte,
  input  wire logic signed [31:0] displacement,
  input  wire logic [3:0]         base_reg,
  input  wire logic [3:0]         data_reg,
  output xmoe_pkg::enc_t          enc
);

  logic [xmoe_pkg::PosW-1:0] pos;
  xmoe_pkg::mod_t            mod;
  logic                      fits8;
  logic                      rex_r;
  logic                      rex_b;
  logic [2:0]                rm;

  always_comb begin
    rex_r = data_reg[3];
    rex_b = base_reg[3];
    fits8 = (displacement[31:7] == '0) || (displacement[31:7] == '1);
    if ((displacement == '0) && (base_reg[2:0] != xmoe_pkg::RM_RIPBP)) begin
      mod = xmoe_pkg::MOD_NODISP;
    end else if (fits8) begin
      mod = xmoe_pkg::MOD_DISP8;
    end else begin
      mod = xmoe_pkg::MOD_DISP32;
    end
    rm = (base_reg[2:0] == xmoe_pkg::RM_SIB) ? xmoe_pkg::RM_SIB : base_reg[2:0];

    pos       = '0;
    enc.bytes = '0;
    if (cmd == xmoe_pkg::FORM_GP) begin
      enc.bytes[pos] = xmoe_pkg::REX_BASE | {4'b0000, 1'b1, rex_r, 1'b0, rex_b};
      pos = pos + 1'b1;
    end else begin
      if (prefix_byte != 8'h00) begin
        enc.bytes[pos] = prefix_byte;
        pos = pos + 1'b1;
      end
      if (rex_r || rex_b) begin
        enc.bytes[pos] = xmoe_pkg::REX_BASE | {4'b0000, 1'b0, rex_r, 1'b0, rex_b};
        pos = pos + 1'b1;
      end
      enc.bytes[pos] = xmoe_pkg::ESC_0F;
      pos = pos + 1'b1;
    end
    enc.bytes[pos] = opcode_byte;
    pos = pos + 1'b1;
    enc.bytes[pos] = {mod, data_reg[2:0], rm};
    pos = pos + 1'b1;
    if (base_reg[2:0] == xmoe_pkg::RM_SIB) begin
      enc.bytes[pos] = xmoe_pkg::SIB_NOIDX | {5'b00000, base_reg[2:0]};
      pos = pos + 1'b1;
    end
    if (mod == xmoe_pkg::MOD_DISP8) begin
      enc.bytes[pos] = displacement[7:0];
      pos = pos + 1'b1;
    end else if (mod == xmoe_pkg::MOD_DISP32) begin
      enc.bytes[pos] = displacement[7:0];
      pos = pos + 1'b1;
      enc.bytes[pos] = displacement[15:8];
      pos = pos + 1'b1;
      enc.bytes[pos] = displacement[23:16];
      pos = pos + 1'b1;
      enc.bytes[pos] = displacement[31:24];
      pos = pos + 1'b1;
    end
    // final byte lands at index MaxBytes-1 at most, so the count is pos of the next slot
    enc.count = (pos == '0) ? xmoe_pkg::CntW'(xmoe_pkg::MaxBytes)
                            : xmoe_pkg::CntW'(pos);
  end

endmodule
`default_nettype wire

>>> sv/xmoe_serial.sv
// Byte serializer: loads an encoded byte string and shifts it out one byte per transfer.
// Depends on xmoe_pkg.
`default_nettype none
module xmoe_serial (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           enc_valid,
  output logic                load,
  input  wire xmoe_pkg::enc_t enc,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          code_byte,
  output logic                last
);

  logic [xmoe_pkg::MaxBytes-1:0][7:0] data;
  logic [xmoe_pkg::CntW-1:0]          rem;
  logic                               valid;
  logic                               xfer;

  assign xfer      = valid && out_ready;
  assign last      = (rem == xmoe_pkg::CntW'(1));
  assign load      = enc_valid && (!valid || (xfer && last));
  assign out_valid = valid;
  assign code_byte = data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rem   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      rem   <= enc.count;
    end else if (xfer) begin
      valid <= !last;
      rem   <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= enc.bytes;
    end else if (xfer) begin
      data <= {8'h00, data[xmoe_pkg::MaxBytes-1:1]};
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (rem != '0) && (rem <= xmoe_pkg::CntW'(xmoe_pkg::MaxBytes)))
    else $error("byte count out of range while busy");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> valid && (rem >= xmoe_pkg::CntW'(3)))
    else $error("loaded instruction shorter than three bytes");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (xfer && last && !load) |=> !valid)
    else $error("serializer busy after final byte");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (xfer && !last) |=> valid && (rem == $past(rem) - 1'b1))
    else $error("byte count did not step");

endmodule
`default_nettype wire

>>> tb/x86_memory_operand_encoder_top_tb.sv
// Self-checking testbench for x86_memory_operand_encoder_top: predicts the code bytes of each
// request and checks every byte and its last flag, across varied valid/ready idling.
// Depends on xmoe_pkg and the encoder RTL.
`timescale 1ns / 100ps
module x86_memory_operand_encoder_top_tb;

  localparam int CycleLimit = 200000;
  localparam logic [7:0] RexW = 8'h08;
  localparam logic signed [31:0] DispEdges [6] = '{
    32'sd127, 32'sd128, -32'sd128, -32'sd129, 32'h7fffffff, 32'h80000000
  };

  typedef struct packed {
    logic [7:0] code;
    logic       tail;
  } code_slot_t;

  class encoding_board;
    code_slot_t pending_q[$];
    int mismatches;
    int bytes_seen;
    int requests;
    int sse_reqs;
    int sib_reqs;
    int disp32_reqs;
    int longest;

    function void note_request(xmoe_pkg::form_t form, logic [7:0] opc, logic [7:0] pfx,
                               logic signed [31:0] disp, logic [3:0] base,
                               logic [3:0] data);
      logic [7:0] enc[$];
      xmoe_pkg::mod_t md;
      logic [2:0] blo;
      logic [7:0] rex_rb;
      blo = base[2:0];
      rex_rb = {5'b0, data[3], 1'b0, base[3]};
      if (disp == 0 && blo != xmoe_pkg::RM_RIPBP) md = xmoe_pkg::MOD_NODISP;
      else if (disp >= -128 && disp <= 127) md = xmoe_pkg::MOD_DISP8;
      else md = xmoe_pkg::MOD_DISP32;
      if (form == xmoe_pkg::FORM_GP) begin
        enc.push_back(xmoe_pkg::REX_BASE | RexW | rex_rb);
      end else begin
        if (pfx != 8'h00) enc.push_back(pfx);
        if (rex_rb != 8'h00) enc.push_back(xmoe_pkg::REX_BASE | rex_rb);
        enc.push_back(xmoe_pkg::ESC_0F);
        sse_reqs++;
      end
      enc.push_back(opc);
      enc.push_back({md, data[2:0], blo});
      if (blo == xmoe_pkg::RM_SIB) begin
        enc.push_back(xmoe_pkg::SIB_NOIDX | {5'b0, blo});
        sib_reqs++;
      end
      if (md == xmoe_pkg::MOD_DISP8) begin
        enc.push_back(disp[7:0]);
      end else if (md == xmoe_pkg::MOD_DISP32) begin
        enc.push_back(disp[7:0]);
        enc.push_back(disp[15:8]);
        enc.push_back(disp[23:16]);
        enc.push_back(disp[31:24]);
        disp32_reqs++;
      end
      foreach (enc[i]) pending_q.push_back('{enc[i], i == enc.size() - 1});
      if (enc.size() > longest) longest = enc.size();
      requests++;
    endfunction

    function void check_byte(logic [7:0] code, logic tail);
      code_slot_t want;
      bytes_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected byte %02h last=%0b with nothing pending", code, tail);
        return;
      end
      want = pending_q.pop_front();
      if (code !== want.code || tail !== want.tail) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch at byte %0d: expected %02h last=%0b, got %02h last=%0b",
                   bytes_seen, want.code, want.tail, code, tail);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               cmd;
  logic [7:0]         opcode_byte;
  logic [7:0]         prefix_byte;
  logic signed [31:0] displacement;
  logic [3:0]         base_reg;
  logic [3:0]         data_reg;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         code_byte;
  logic               last;

  encoding_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycle_count;

  x86_memory_operand_encoder_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .opcode_byte(opcode_byte),
    .prefix_byte(prefix_byte),
    .displacement(displacement),
    .base_reg(base_reg),
    .data_reg(data_reg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_byte(code_byte),
    .last(last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_byte(code_byte, last);
  end

  task automatic send_request(input logic f, input logic [7:0] opc, input logic [7:0] pfx,
                              input logic signed [31:0] disp, input logic [3:0] base,
                              input logic [3:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd = f;
    opcode_byte = opc;
    prefix_byte = pfx;
    displacement = disp;
    base_reg = base;
    data_reg = data;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(xmoe_pkg::form_t'(f), opc, pfx, disp, base, data);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic signed [31:0] d;
    logic [7:0] p;
    case ($urandom_range(5))
      0: d = 32'sd0;
      1: d = 32'($urandom_range(255)) - 32'd128;
      2: d = 32'($urandom_range(65535)) - 32'd32768;
      3: d = DispEdges[$urandom_range(5)];
      default: d = $urandom;
    endcase
    p = $urandom_range(1) ? 8'($urandom) : 8'h00;
    send_request(1'($urandom_range(1)), 8'($urandom), p, d, 4'($urandom), 4'($urandom));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = xmoe_pkg::FORM_GP;
    opcode_byte = 8'h00;
    prefix_byte = 8'h00;
    displacement = 32'sd0;
    base_reg = 4'd0;
    data_reg = 4'd0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycle_count = 0;
    board = new;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: mod boundaries, rbp/r13 and rsp/r12 bases, prefix and REX rules
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'hff, 32'sd0,        4'd0,  4'd0);
    send_request(xmoe_pkg::FORM_GP,  8'h89, 8'h00, -32'sd1,       4'd15, 4'd15);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, 32'sd0,        4'd5,  4'd3);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h66, 32'sd0,        4'd13, 4'd8);
    send_request(xmoe_pkg::FORM_GP,  8'h89, 8'h00, 32'sd0,        4'd4,  4'd2);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, 32'h7fffffff,  4'd12, 4'd6);
    send_request(xmoe_pkg::FORM_GP,  8'h89, 8'h00, 32'h80000000,  4'd4,  4'd9);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, 32'sd127,      4'd2,  4'd1);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, 32'sd128,      4'd2,  4'd1);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, -32'sd128,     4'd6,  4'd5);
    send_request(xmoe_pkg::FORM_GP,  8'h8b, 8'h00, -32'sd129,     4'd6,  4'd5);
    send_request(xmoe_pkg::FORM_GP,  8'h00, 8'h00, 32'h55aa55aa,  4'd7,  4'd7);
    send_request(xmoe_pkg::FORM_SSE, 8'h10, 8'h00, 32'sd0,        4'd0,  4'd0);
    send_request(xmoe_pkg::FORM_SSE, 8'h11, 8'hf3, 32'sd8,        4'd1,  4'd9);
    send_request(xmoe_pkg::FORM_SSE, 8'h28, 8'h66, 32'sd0,        4'd9,  4'd1);
    send_request(xmoe_pkg::FORM_SSE, 8'h58, 8'hf2, 32'h12345678,  4'd12, 4'd15);
    send_request(xmoe_pkg::FORM_SSE, 8'h10, 8'h00, 32'sd0,        4'd5,  4'd7);
    send_request(xmoe_pkg::FORM_SSE, 8'h59, 8'hff, -32'sd200000,  4'd13, 4'd0);
    send_request(xmoe_pkg::FORM_SSE, 8'hff, 8'h01, 32'sd1,        4'd3,  4'd4);
    send_request(xmoe_pkg::FORM_SSE, 8'h00, 8'h80, -32'sd2,       4'd14, 4'd10);
    send_request(xmoe_pkg::FORM_SSE, 8'h2a, 8'h00, 32'sd0,        4'd4,  4'd12);
    wait_drained();

    // receiver holds off while the sender keeps offering, then sender waits for drain
    hold_cycles = 80;
    repeat (12) send_random();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (35) send_random();
      wait_drained();
    end

    in_valid = 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Encoded %0d instructions (%0d SSE, %0d SIB base, %0d disp32, longest %0d bytes)",
             board.requests, board.sse_reqs, board.sib_reqs, board.disp32_reqs, board.longest);
    $display("Checked %0d code bytes over four idle/stall mixes and one long output hold-off",
             board.bytes_seen);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
